### hdl/fpdp_pkg.sv
package fpdp_pkg;

  // Canonical quiet NaN for every NaN that the block produces.
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // Class of a product, settled before the mantissa path is used.
  typedef enum logic [1:0] {
    KIND_FIN,
    KIND_ZERO,
    KIND_INF,
    KIND_NAN
  } kind_e;

  // One rounded product on its way from the front to the back.
  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } prod_t;

  // Leading zero count of a 48-bit word; an all-zero word gives 48.
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) begin
          hit = 1'b1;
        end else begin
          n = n + 6'd1;
        end
      end
    end
    return n;
  endfunction

endpackage

### hdl/fpdp_if.sv
// Element pair channel.
interface fpdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] a_bits;
  logic [31:0] b_bits;
  logic        last_element;

  modport source (output valid, a_bits, b_bits, last_element, input ready);
  modport sink (input valid, a_bits, b_bits, last_element, output ready);
endinterface

// Result channel.
interface fpdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_bits;

  modport source (output valid, sum_bits, input ready);
  modport sink (input valid, sum_bits, output ready);
endinterface

### hdl/fpdp_front.sv
module fpdp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [31:0]     a_bits_i,
  input  logic [31:0]     b_bits_i,
  input  logic            last_i,
  output logic            push_o,
  input  logic            push_ready_i,
  output fpdp_pkg::prod_t push_data_o
);

  // Stage control: a stage moves on when it is empty or its successor moves.
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;

  assign adv3       = !v3_q || push_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign push_o     = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // Stage 1: classify operands and multiply the mantissas.
  logic [7:0]  ea, eb;
  logic [22:0] fa, fb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  eae, ebe;
  fpdp_pkg::kind_e kind1_d;

  assign ea = a_bits_i[30:23];
  assign eb = b_bits_i[30:23];
  assign fa = a_bits_i[22:0];
  assign fb = b_bits_i[22:0];
  assign a_nan  = (ea == 8'hFF) && (fa != '0);
  assign b_nan  = (eb == 8'hFF) && (fb != '0);
  assign a_inf  = (ea == 8'hFF) && (fa == '0);
  assign b_inf  = (eb == 8'hFF) && (fb == '0);
  assign a_zero = (ea == 8'h00) && (fa == '0);
  assign b_zero = (eb == 8'h00) && (fb == '0);
  assign ma  = {ea != 8'h00, fa};
  assign mb  = {eb != 8'h00, fb};
  assign eae = (ea == 8'h00) ? 8'd1 : ea;
  assign ebe = (eb == 8'h00) ? 8'd1 : eb;

  always_comb begin
    if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
      kind1_d = fpdp_pkg::KIND_NAN;
    end else if (a_inf || b_inf) begin
      kind1_d = fpdp_pkg::KIND_INF;
    end else if (a_zero || b_zero) begin
      kind1_d = fpdp_pkg::KIND_ZERO;
    end else begin
      kind1_d = fpdp_pkg::KIND_FIN;
    end
  end

  logic [47:0]     p1_q;
  logic [8:0]      esum1_q;
  logic            sign1_q, last1_q;
  fpdp_pkg::kind_e kind1_q;

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      p1_q    <= ma * mb;
      esum1_q <= {1'b0, eae} + {1'b0, ebe};
      sign1_q <= a_bits_i[31] ^ b_bits_i[31];
      last1_q <= last_i;
      kind1_q <= kind1_d;
    end
  end

  // Stage 2: normalize the product so that its leading one is at the top.
  logic [5:0]         lz2;
  logic signed [10:0] e2_d;

  assign lz2  = fpdp_pkg::lzc48(p1_q);
  assign e2_d = $signed({2'b00, esum1_q}) - 11'sd126 - $signed({5'b00000, lz2});

  logic [47:0]        pn2_q;
  logic signed [10:0] e2_q;
  logic               sign2_q, last2_q;
  fpdp_pkg::kind_e    kind2_q;

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      pn2_q   <= p1_q << lz2;
      e2_q    <= e2_d;
      sign2_q <= sign1_q;
      last2_q <= last1_q;
      kind2_q <= kind1_q;
    end
  end

  // Stage 3: denormalize if needed and round to nearest even.
  logic signed [10:0] sh_full;
  logic [5:0]         shc;
  logic [47:0]        sd;
  logic               lost;
  logic [23:0]        mant;
  logic               g, st, inc;
  logic [7:0]         efield;
  logic [30:0]        rnd;
  logic [31:0]        res3;

  always_comb begin
    sh_full = 11'sd1 - e2_q;
    shc     = '0;
    sd      = pn2_q;
    lost    = 1'b0;
    efield  = e2_q[7:0];
    if (e2_q < 11'sd1) begin
      shc    = (sh_full > 11'sd48) ? 6'd48 : sh_full[5:0];
      sd     = pn2_q >> shc;
      lost   = |(pn2_q & ~({48{1'b1}} << shc));
      efield = 8'h00;
    end
    mant = sd[47:24];
    g    = sd[23];
    st   = (|sd[22:0]) | lost;
    inc  = g && (st || mant[0]);
    rnd  = {efield, mant[22:0]} + {30'd0, inc};
  end

  always_comb begin
    unique case (kind2_q)
      fpdp_pkg::KIND_NAN:  res3 = fpdp_pkg::CANON_NAN;
      fpdp_pkg::KIND_INF:  res3 = {sign2_q, 8'hFF, 23'd0};
      fpdp_pkg::KIND_ZERO: res3 = {sign2_q, 31'd0};
      default: begin
        if (e2_q > 11'sd254) begin
          res3 = {sign2_q, 8'hFF, 23'd0};
        end else begin
          res3 = {sign2_q, rnd};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      push_data_o.bits <= res3;
      push_data_o.last <= last2_q;
    end
  end

endmodule

### hdl/fpdp_fifo.sv
module fpdp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  fpdp_pkg::prod_t push_data_i,
  output logic            head_valid_o,
  input  logic            pop_i,
  output fpdp_pkg::prod_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fpdp_pkg::prod_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  // Storage is written at the tail of the queue.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (do_pop)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from an empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue fill count out of range");

endmodule

### hdl/fpdp_back.sv
module fpdp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  fpdp_pkg::prod_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     sum_o
);

  logic [31:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] sum_d;
  logic        out_free;

  // Operand decode for the accumulate add.
  logic [31:0] x, y, big, sml;
  logic        x_nan, y_nan, x_inf, y_inf, swap, sub;
  logic [7:0]  eb_eff, es_eff, d;
  logic [26:0] m1, ext, m2;
  logic [27:0] s;
  logic [5:0]  lz, sh, lim;
  logic [26:0] n;
  logic [8:0]  en;
  logic [7:0]  efield;
  logic        inc;
  logic [30:0] rnd;

  assign x = acc_q;
  assign y = head_i.bits;

  always_comb begin
    x_nan  = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    y_nan  = (y[30:23] == 8'hFF) && (y[22:0] != '0);
    x_inf  = (x[30:23] == 8'hFF) && (x[22:0] == '0);
    y_inf  = (y[30:23] == 8'hFF) && (y[22:0] == '0);
    swap   = y[30:0] > x[30:0];
    big    = swap ? y : x;
    sml    = swap ? x : y;
    eb_eff = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
    d      = eb_eff - es_eff;
    sub    = big[31] ^ sml[31];
    m1     = {big[30:23] != 8'h00, big[22:0], 3'b000};
    ext    = {sml[30:23] != 8'h00, sml[22:0], 3'b000};
    // Align the smaller operand, folding shifted-out bits into sticky.
    if (d >= 8'd27) begin
      m2 = {26'd0, ext != '0};
    end else begin
      m2 = (ext >> d[4:0]) | {26'd0, |(ext & ~({27{1'b1}} << d[4:0]))};
    end
    s = sub ? ({1'b0, m1} - {1'b0, m2}) : ({1'b0, m1} + {1'b0, m2});
    // Normalize, never below the smallest exponent.
    lz  = fpdp_pkg::lzc48({s[26:0], 21'd0});
    lim = (eb_eff > 8'd48) ? 6'd48 : 6'(eb_eff - 8'd1);
    sh  = (lz < lim) ? lz : lim;
    if (s[27]) begin
      n  = {s[27:2], s[1] | s[0]};
      en = {1'b0, eb_eff} + 9'd1;
    end else begin
      n  = s[26:0] << sh;
      en = {1'b0, eb_eff} - {3'd0, sh};
    end
    efield = n[26] ? en[7:0] : 8'h00;
    inc    = n[2] && (n[1] || n[0] || n[3]);
    rnd    = {efield, n[25:3]} + {30'd0, inc};
    // Special operands, exact zero and overflow override the datapath.
    if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31]))) begin
      sum_d = fpdp_pkg::CANON_NAN;
    end else if (x_inf) begin
      sum_d = x;
    end else if (y_inf) begin
      sum_d = y;
    end else if (s == '0) begin
      sum_d = {x[31] & y[31], 31'd0};
    end else if (en >= 9'd255) begin
      sum_d = {big[31], 8'hFF, 23'd0};
    end else begin
      sum_d = {big[31], rnd};
    end
  end

  // A last transaction waits only while the result register is still held.
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = head_valid_i && (!head_i.last || out_free);

  always_comb begin
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (pop_o) begin
      acc_d = head_i.last ? 32'd0 : sum_d;
      if (head_i.last) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.last) sum_o <= sum_d;
  end

  assign out_valid_o = out_valid_q;

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && head_i.last) |=> acc_q == '0)
    else $error("accumulator not cleared after a vector");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_o && head_i.last))
    else $error("result raised without a last element");

endmodule

### hdl/fp32_dot_product.sv
// Streaming binary32 dot product.
// in_i carries one element pair per transaction (a_bits, b_bits, last_element).
// Each pair is multiplied with round-to-nearest-even, and the product is
// added to a running binary32 sum, rounded again; products are summed in order.
// On the transaction marked last, out_o delivers one transaction with the
// final sum in sum_bits, and the running sum returns to positive zero.
// Throughput is one pair per cycle while nothing stalls; the accumulate add
// is the loop that sets it. A result passes the three multiply stages, the
// product queue and then the add into the output register.
// Reset clears the running sum, the queue and all valid flags; the block
// is ready for a pair as soon as reset is released.
// When the receiver stalls, the result is held in the output register and
// further pairs keep being accepted and summed; only a second last element
// waits, and once the queue of FifoDepth products and the multiply stages
// fill up, in_i drops ready.
// NaN results are always returned as the quiet NaN 0x7FC00000.
module fp32_dot_product #(
  parameter int unsigned FifoDepth = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  fpdp_in_if.sink   in_i,
  fpdp_out_if.source out_o
);

  logic            push, push_ready, head_valid, pop;
  fpdp_pkg::prod_t push_data, head;

  // Multiply and round front end.
  fpdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .a_bits_i     (in_i.a_bits),
    .b_bits_i     (in_i.b_bits),
    .last_i       (in_i.last_element),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Product queue.
  fpdp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  // Accumulator and result register.
  fpdp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .sum_o        (out_o.sum_bits)
  );

endmodule
